@@ rtl/core/upd_pkg.sv @@
// Shared types, character codes and hex helpers for the URL percent decoder.
`default_nettype none
package upd_pkg;

   // Character codes
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam int         HEX_RADIX    = 16;
   localparam int         NIBBLE_W     = $clog2(HEX_RADIX);

   // Request bundle queue between the front and back parts
   localparam int MAX_OUT     = 3;
   localparam int SLOT_W      = $clog2(MAX_OUT);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Escape tracking
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   // Decoded bytes caused by one request
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] data;
      logic [SLOT_W-1:0]       count;
      logic                    fin;
   } bundle_type;

   function automatic logic is_hex(input logic [7:0] c);
      logic res;
      res = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
            (c >= 8'h61 && c <= 8'h66);
      return res;
   endfunction

   function automatic logic [NIBBLE_W-1:0] hex_val(input logic [7:0] c);
      logic [7:0] diff;
      diff = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         diff = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         diff = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         diff = c - 8'h57;
      end
      return diff[NIBBLE_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/upd_front.sv @@
// Front part: accepts encoded bytes, tracks the escape and builds result bundles.
`default_nettype none
module upd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_in_byte,
   input  wire logic                req_in_final,
   input  wire logic                q_full,
   output logic                     q_push,
   output upd_pkg::bundle_type      q_bundle
);
   import upd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic        accept;
   logic        do_plain;
   logic        c_hex;
   logic [MAX_OUT-1:0][7:0] slot;
   logic [SLOT_W-1:0]       cnt;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign c_hex     = is_hex(req_in_byte);

   // Classify the byte against the pending escape and collect outputs
   always_comb begin
      slot     = '0;
      cnt      = '0;
      phase_in = phase_ff;
      held_in  = held_ff;
      do_plain = 1'b0;
      case (phase_ff)
         PH_PCT: begin
            if (c_hex) begin
               held_in  = req_in_byte;
               phase_in = PH_DIGIT;
            end else begin
               phase_in  = PH_IDLE;
               slot[cnt] = CHAR_PERCENT;
               cnt       = cnt + 1'b1;
               do_plain  = 1'b1;
            end
         end
         PH_DIGIT: begin
            phase_in = PH_IDLE;
            held_in  = 8'h00;
            if (c_hex) begin
               slot[cnt] = {hex_val(held_ff), hex_val(req_in_byte)};
               cnt       = cnt + 1'b1;
            end else begin
               slot[cnt] = CHAR_PERCENT;
               cnt       = cnt + 1'b1;
               slot[cnt] = held_ff;
               cnt       = cnt + 1'b1;
               do_plain  = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            do_plain = 1'b1;
         end
      endcase

      // Decode the byte with no escape pending
      if (do_plain) begin
         if (req_in_byte == CHAR_PLUS) begin
            slot[cnt] = CHAR_SPACE;
            cnt       = cnt + 1'b1;
         end else if (req_in_byte == CHAR_PERCENT) begin
            phase_in = PH_PCT;
         end else begin
            slot[cnt] = req_in_byte;
            cnt       = cnt + 1'b1;
         end
      end

      // Flush whatever is held at string end
      if (req_in_final) begin
         if (phase_in == PH_PCT) begin
            slot[cnt] = CHAR_PERCENT;
            cnt       = cnt + 1'b1;
         end else if (phase_in == PH_DIGIT) begin
            slot[cnt] = CHAR_PERCENT;
            cnt       = cnt + 1'b1;
            slot[cnt] = held_in;
            cnt       = cnt + 1'b1;
         end
         phase_in = PH_IDLE;
         held_in  = 8'h00;
      end
   end

   assign q_push         = accept && (cnt != '0);
   assign q_bundle.data  = slot;
   assign q_bundle.count = cnt;
   assign q_bundle.fin   = req_in_final;

   // Advance escape state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

`ifndef SYNTHESIS
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_final |=> phase_ff == PH_IDLE && held_ff == 8'h00)
      else $error("escape state not cleared after final byte");
   a_fin_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_final |-> q_push)
      else $error("final byte produced no result");
   a_silent_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !q_push |=> phase_ff != PH_IDLE)
      else $error("request dropped without holding an escape");
`endif

endmodule
`default_nettype wire

@@ rtl/core/upd_queue.sv @@
// Short bundle queue between the front and back parts.
`default_nettype none
module upd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire upd_pkg::bundle_type push_bundle,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output upd_pkg::bundle_type      head
);
   import upd_pkg::*;

   bundle_type          mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed bundles
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_bundle;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 || count_ff == QCNT_W'(QUEUE_DEPTH) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

@@ rtl/core/upd_back.sv @@
// Back part: unpacks bundles to its register one byte a cycle unless stalled.
`default_nettype none
module upd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire upd_pkg::bundle_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_run_last,
   output logic                     rsp_string_end
);
   import upd_pkg::*;

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff;
   logic              run_last_ff;
   logic              string_end_ff;
   logic              load;
   logic              last;

   assign load = head_valid && (!valid_ff || rsp_ready);
   assign last = idx_ff == head.count - 1'b1;
   assign pop  = load && last;

   // Step through the slots of the head bundle
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         idx_in   = last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= head.data[idx_ff];
         run_last_ff   <= last;
         string_end_ff <= last && head.fin;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_string_end = string_end_ff;

`ifndef SYNTHESIS
   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff < head.count)
      else $error("slot index beyond bundle");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && string_end_ff |-> run_last_ff)
      else $error("string end on a non-final result");
   a_idx_rest: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == '0)
      else $error("slot index left mid-bundle");
`endif

endmodule
`default_nettype wire

@@ rtl/core/url_percent_decoder_top.sv @@
// Top level of the streaming URL form percent decoder.
// Results of a request pass through the bundle queue, then the back output register.
// Throughput: one request per cycle while each yields at most one result and
// rsp_ready is high; the back part emits one decoded byte per cycle while rsp_ready
// is high, so the four-entry queue absorbs broken escapes (up to three results).
// Reset (synchronous, active high) clears the escape state, the queue and the output.
`default_nettype none
module url_percent_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_final,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_string_end
);
   import upd_pkg::*;

   logic       q_full;
   logic       q_push;
   bundle_type q_bundle;
   logic       q_pop;
   logic       q_head_valid;
   bundle_type q_head;

   upd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_final (req_in_final),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_bundle     (q_bundle)
   );

   upd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_bundle (q_bundle),
      .full        (q_full),
      .pop         (q_pop),
      .head_valid  (q_head_valid),
      .head        (q_head)
   );

   upd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_head_valid),
      .head           (q_head),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule
`default_nettype wire
